### design/gbn_pkg.sv
// Shared types, constants and sequence arithmetic for the go-back-N link endpoint.
package gbn_pkg;

    localparam int CMD_W        = 2;
    localparam int KIND_W       = 2;
    localparam int SEQ_W        = 3;
    localparam int PAYLOAD_W    = 32;
    localparam int MAX_SEQUENCE = 7;
    localparam int MODULUS      = MAX_SEQUENCE + 1;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    typedef logic [SEQ_W-1:0]     t_seq;
    typedef logic [PAYLOAD_W-1:0] t_payload;

    typedef enum logic [CMD_W-1:0] {
        OP_SEND    = 2'd0,
        OP_FRAME   = 2'd1,
        OP_CHKERR  = 2'd2,
        OP_TIMEOUT = 2'd3
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_SEND    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEND,
        ST_DELIVER,
        ST_ACK,
        ST_RESEND,
        ST_STATUS
    } t_back_state;

    typedef struct packed {
        t_op      op;
        t_seq     rx_seq;
        t_seq     rx_ack;
        t_payload payload;
    } t_cmd;

    typedef struct packed {
        t_kind    kind;
        t_seq     seq_out;
        t_seq     ack_out;
        t_payload payload_out;
        logic     network_enable;
        logic     refused;
        logic     last;
    } t_result;

    // Queue handshake between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic t_seq seq_inc(input t_seq s);
        return (s == t_seq'(MAX_SEQUENCE)) ? t_seq'(0) : s + t_seq'(1);
    endfunction

    function automatic t_seq seq_dec(input t_seq s);
        return (s == t_seq'(0)) ? t_seq'(MAX_SEQUENCE) : s - t_seq'(1);
    endfunction

    // True when a <= b < c going around the sequence circle
    function automatic logic in_window(input t_seq a, input t_seq b, input t_seq c);
        return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
    endfunction

endpackage

### design/gbn_in_if.sv
// Event channel into the link endpoint.
interface gbn_in_if import gbn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [SEQ_W-1:0]     rx_seq;
    logic [SEQ_W-1:0]     rx_ack;
    logic [PAYLOAD_W-1:0] payload_in;

    modport source (output valid, command, rx_seq, rx_ack, payload_in, input ready);
    modport sink   (input valid, command, rx_seq, rx_ack, payload_in, output ready);
endinterface

### design/gbn_out_if.sv
// Result channel out of the link endpoint.
interface gbn_out_if import gbn_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [SEQ_W-1:0]     seq_out;
    logic [SEQ_W-1:0]     ack_out;
    logic [PAYLOAD_W-1:0] payload_out;
    logic                 network_enable;
    logic                 refused;
    logic                 last;

    modport source (output valid, kind, seq_out, ack_out, payload_out, network_enable,
                    refused, last, input ready);
    modport sink   (input valid, kind, seq_out, ack_out, payload_out, network_enable,
                    refused, last, output ready);
endinterface

### design/gbn_front.sv
// Front end: accepts events, decodes the command and pushes them into the queue.
module gbn_front import gbn_pkg::*; (
    gbn_in_if.sink        i_in,
    input  t_queue_status i_q_status,
    output logic          o_push,
    output t_cmd          o_push_data
);

    // Take a transfer whenever the queue has room
    assign i_in.ready = !i_q_status.full;
    assign o_push     = i_in.valid && !i_q_status.full;

    // Decode the event; fields a command does not use are dropped
    always_comb begin
        o_push_data         = '0;
        o_push_data.op      = t_op'(i_in.command);
        o_push_data.payload = i_in.payload_in;
        case (t_op'(i_in.command))
            OP_FRAME: begin
                o_push_data.rx_seq = i_in.rx_seq;
                o_push_data.rx_ack = i_in.rx_ack;
            end
            OP_SEND: begin
                o_push_data.rx_seq = '0;
                o_push_data.rx_ack = '0;
            end
            default: begin
                o_push_data.payload = '0;
            end
        endcase
    end

endmodule

### design/gbn_queue.sv
// Short event queue between the front and back ends.
module gbn_queue import gbn_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_cmd          i_push_data,
    input  logic          i_pop,
    output t_cmd          o_head,
    output t_queue_status o_status
);

    t_cmd                r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_AW:0]   r_fill, n_fill;
    logic                do_push, do_pop;

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    assign o_status.full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_head         = r_entry[r_rd_ptr];

    // Advance pointers and fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = r_wr_ptr + QUEUE_AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = r_rd_ptr + QUEUE_AW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_fill = r_fill + (QUEUE_AW+1)'(1);
            2'b01:   n_fill = r_fill - (QUEUE_AW+1)'(1);
            default: n_fill = r_fill;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // Store the pushed event
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### design/gbn_back.sv
// Back end: protocol state, payload store and the result sequencer.
module gbn_back import gbn_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_head,
    input  t_queue_status i_q_status,
    output logic          o_pop,
    gbn_out_if.source     o_out
);

    t_back_state r_state, n_state;
    t_seq        r_next_send, n_next_send;
    t_seq        r_oldest, n_oldest;
    t_seq        r_expected, n_expected;
    t_seq        r_count, n_count;
    t_seq        r_left, n_left;
    logic        r_refused, n_refused;
    t_cmd        r_cmd, n_cmd;
    logic        r_out_valid;
    t_result     r_out;
    t_payload    r_store [MODULUS];
    t_payload    r_rd_data;

    logic        slot_free;
    logic        ack_hit;
    logic        emit;
    t_result     res;
    logic        store_we;

    assign slot_free = !r_out_valid || o_out.ready;
    assign ack_hit   = (r_count != t_seq'(0)) &&
                       in_window(r_oldest, r_cmd.rx_ack, r_next_send);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    case (i_head.op)
                        OP_SEND:
                            n_state = (r_count >= t_seq'(MAX_SEQUENCE)) ? ST_STATUS : ST_SEND;
                        OP_FRAME:
                            n_state = (i_head.rx_seq == r_expected) ? ST_DELIVER : ST_ACK;
                        OP_CHKERR:
                            n_state = ST_STATUS;
                        default:
                            n_state = ST_RESEND;
                    endcase
                end
            end
            ST_SEND: begin
                if (slot_free) begin
                    n_state = ST_STATUS;
                end
            end
            ST_DELIVER: begin
                if (slot_free) begin
                    n_state = ST_ACK;
                end
            end
            ST_ACK: begin
                if (!ack_hit) begin
                    n_state = ST_STATUS;
                end
            end
            ST_RESEND: begin
                if (r_left == t_seq'(0)) begin
                    n_state = ST_STATUS;
                end
            end
            ST_STATUS: begin
                if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath updates and result generation
    always_comb begin
        n_next_send = r_next_send;
        n_oldest    = r_oldest;
        n_expected  = r_expected;
        n_count     = r_count;
        n_left      = r_left;
        n_refused   = r_refused;
        n_cmd       = r_cmd;
        o_pop       = 1'b0;
        emit        = 1'b0;
        store_we    = 1'b0;
        res         = '0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_pop     = 1'b1;
                    n_cmd     = i_head;
                    n_refused = (i_head.op == OP_SEND) &&
                                (r_count >= t_seq'(MAX_SEQUENCE));
                    if (i_head.op == OP_TIMEOUT) begin
                        n_next_send = r_oldest;
                        n_left      = r_count;
                    end
                end
            end
            ST_SEND: begin
                if (slot_free) begin
                    emit            = 1'b1;
                    res.kind        = KIND_SEND;
                    res.seq_out     = r_next_send;
                    res.ack_out     = seq_dec(r_expected);
                    res.payload_out = r_cmd.payload;
                    store_we        = 1'b1;
                    n_count         = r_count + t_seq'(1);
                    n_next_send     = seq_inc(r_next_send);
                end
            end
            ST_DELIVER: begin
                if (slot_free) begin
                    emit            = 1'b1;
                    res.kind        = KIND_DELIVER;
                    res.payload_out = r_cmd.payload;
                    n_expected      = seq_inc(r_expected);
                end
            end
            ST_ACK: begin
                if (ack_hit && slot_free) begin
                    emit        = 1'b1;
                    res.kind    = KIND_STOP;
                    res.seq_out = r_oldest;
                    n_count     = r_count - t_seq'(1);
                    n_oldest    = seq_inc(r_oldest);
                end
            end
            ST_RESEND: begin
                if ((r_left != t_seq'(0)) && slot_free) begin
                    emit            = 1'b1;
                    res.kind        = KIND_SEND;
                    res.seq_out     = r_next_send;
                    res.ack_out     = seq_dec(r_expected);
                    res.payload_out = r_rd_data;
                    n_next_send     = seq_inc(r_next_send);
                    n_left          = r_left - t_seq'(1);
                end
            end
            ST_STATUS: begin
                if (slot_free) begin
                    emit               = 1'b1;
                    res.kind           = KIND_STATUS;
                    res.network_enable = (r_count < t_seq'(MAX_SEQUENCE));
                    res.refused        = r_refused;
                    res.last           = 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next_send <= '0;
            r_oldest    <= '0;
            r_expected  <= '0;
            r_count     <= '0;
            r_left      <= '0;
            r_refused   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_send <= n_next_send;
            r_oldest    <= n_oldest;
            r_expected  <= n_expected;
            r_count     <= n_count;
            r_left      <= n_left;
            r_refused   <= n_refused;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the current event and the output slot
    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (emit) begin
            r_out <= res;
        end
    end

    // Payload store; the read follows the next send pointer so data is ready in time
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[r_next_send] <= r_cmd.payload;
        end
        r_rd_data <= r_store[n_next_send];
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.seq_out        = r_out.seq_out;
    assign o_out.ack_out        = r_out.ack_out;
    assign o_out.payload_out    = r_out.payload_out;
    assign o_out.network_enable = r_out.network_enable;
    assign o_out.refused        = r_out.refused;
    assign o_out.last           = r_out.last;

endmodule

### design/go_back_n_link_endpoint.sv
// Top level of the go-back-N link endpoint.
//
// Events (send, frame arrived, checksum error, timeout) enter through a two-entry
// queue and are carried out one at a time by the back-end sequencer, which emits
// at most one result per cycle into a registered output slot and closes every
// event with a status transfer (last = 1). A checksum error or a refused send
// goes straight to status; a send emits its frame, a timeout resends n frames
// and an arriving frame is delivered if in order and releases up to seven
// timers before status. The sequencer emits one result per cycle while the output
// slot is free, takes each event from the queue in a step of its own and closes
// the ack scan or resend loop in a step that emits nothing. While an event runs,
// the front end keeps accepting up to two further events. Resent payloads come
// from an 8-entry store; reading a slot that was never sent is not defined.
module go_back_n_link_endpoint import gbn_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out
);

    logic          push;
    t_cmd          push_data;
    logic          pop;
    t_cmd          head;
    t_queue_status q_status;

    gbn_front u_front (
        .i_in        (i_in),
        .i_q_status  (q_status),
        .o_push      (push),
        .o_push_data (push_data)
    );

    gbn_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_status    (q_status)
    );

    gbn_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_out      (o_out)
    );

endmodule

### design/gbn_checker.sv
// Port-level checks on the result channel of the link endpoint, bound to the top level.
module gbn_checker import gbn_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic [KIND_W-1:0]    i_kind,
    input logic [SEQ_W-1:0]     i_seq_out,
    input logic [SEQ_W-1:0]     i_ack_out,
    input logic [PAYLOAD_W-1:0] i_payload_out,
    input logic                 i_network_enable,
    input logic                 i_refused,
    input logic                 i_last
);

    // A stalled result keeps its contents
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=> (i_valid && $stable(i_kind) && $stable(i_seq_out) &&
                                   $stable(i_payload_out) && $stable(i_last)))
        else $error("stalled result changed");

    // Last marks exactly the status transfer
    a_last_is_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_last == (i_kind == KIND_STATUS)))
        else $error("last does not match status kind");

    // Flags only appear on status
    a_flags_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind != KIND_STATUS)) |-> (!i_network_enable && !i_refused))
        else $error("status flags on a non-status transfer");

    // A refused send means the window is full
    a_refused_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_refused) |-> !i_network_enable)
        else $error("refused with network enabled");

    // Deliveries carry no sequence or ack
    a_deliver_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_kind == KIND_DELIVER)) |-> ((i_seq_out == '0) && (i_ack_out == '0)))
        else $error("delivery with sequence fields set");

endmodule

bind go_back_n_link_endpoint gbn_checker u_gbn_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (o_out.valid),
    .i_ready          (o_out.ready),
    .i_kind           (o_out.kind),
    .i_seq_out        (o_out.seq_out),
    .i_ack_out        (o_out.ack_out),
    .i_payload_out    (o_out.payload_out),
    .i_network_enable (o_out.network_enable),
    .i_refused        (o_out.refused),
    .i_last           (o_out.last)
);

### tb/sv/go_back_n_link_endpoint_tb.sv
// Self-checking testbench for the go-back-N link endpoint: directed table, then random events.
module go_back_n_link_endpoint_tb;
    import gbn_pkg::*;

    localparam int RANDOM_EVENTS = 400;
    localparam int QUIET_TAIL    = 60;
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int LONG_HOLD     = 120;
    localparam int MAX_REPORTS   = 10;
    localparam int N_ROWS        = 22;

    typedef struct packed {
        t_cmd              ev;
        logic [1:0]        n_typed;
        t_result [1:0]     typed;
    } t_stim_row;

    localparam t_result NO_RES = '0;

    logic clk;
    logic rst_n;

    gbn_in_if  in_if ();
    gbn_out_if out_if ();

    go_back_n_link_endpoint u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Endpoint state as the testbench tracks it
    t_seq     mdl_next_seq;
    t_seq     mdl_oldest;
    t_seq     mdl_rx_expected;
    int       mdl_outstanding;
    t_payload sent_payloads [MODULUS];

    t_result  pending_results [$];
    t_stim_row stim_table [N_ROWS];

    int  mismatch_count;
    int  events_accepted;
    int  results_seen;
    int  refusals_seen;
    int  largest_burst;
    int  events_by_op [4];
    int  results_by_kind [4];
    int  cycle_count;
    bit  quiet_phase;
    bit  long_hold_done;

    // Clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic t_result status_res(input logic ne, input logic rf);
        return '{KIND_STATUS, t_seq'(0), t_seq'(0), t_payload'(0), ne, rf, 1'b1};
    endfunction

    function automatic t_result deliver_res(input t_payload pay);
        return '{KIND_DELIVER, t_seq'(0), t_seq'(0), pay, 1'b0, 1'b0, 1'b0};
    endfunction

    function automatic t_result stop_res(input t_seq s);
        return '{KIND_STOP, s, t_seq'(0), t_payload'(0), 1'b0, 1'b0, 1'b0};
    endfunction

    // Frame on the wire carries the ack of the last in-order frame received
    function automatic t_result frame_res(input t_seq s);
        return '{KIND_SEND, s, t_seq'(mdl_rx_expected - t_seq'(1)), sent_payloads[s],
                 1'b0, 1'b0, 1'b0};
    endfunction

    function automatic t_stim_row mk_row(input t_op op, input t_seq rs, input t_seq ra,
                                         input t_payload pay, input int n,
                                         input t_result r0, input t_result r1);
        t_stim_row row;
        row.ev.op      = op;
        row.ev.rx_seq  = rs;
        row.ev.rx_ack  = ra;
        row.ev.payload = pay;
        row.n_typed    = 2'(n);
        row.typed[0]   = r0;
        row.typed[1]   = r1;
        return row;
    endfunction

    // Advance the tracked endpoint state by one event and queue its results
    function automatic void predict_link_event(input t_cmd ev);
        logic turned_away;
        int   base;
        int   n_resend;
        base        = pending_results.size();
        turned_away = 1'b0;
        case (ev.op)
            OP_SEND: begin
                if (mdl_outstanding >= MAX_SEQUENCE) begin
                    turned_away = 1'b1;
                end else begin
                    sent_payloads[mdl_next_seq] = ev.payload;
                    mdl_outstanding++;
                    pending_results.push_back(frame_res(mdl_next_seq));
                    mdl_next_seq = mdl_next_seq + t_seq'(1);
                end
            end
            OP_FRAME: begin
                if (ev.rx_seq == mdl_rx_expected) begin
                    pending_results.push_back(deliver_res(ev.payload));
                    mdl_rx_expected = mdl_rx_expected + t_seq'(1);
                end
                // Cumulative ack: release while the ack lies in [oldest, next)
                while (mdl_outstanding > 0 &&
                       t_seq'(ev.rx_ack - mdl_oldest) < t_seq'(mdl_next_seq - mdl_oldest)) begin
                    mdl_outstanding--;
                    pending_results.push_back(stop_res(mdl_oldest));
                    mdl_oldest = mdl_oldest + t_seq'(1);
                end
            end
            OP_TIMEOUT: begin
                mdl_next_seq = mdl_oldest;
                n_resend     = mdl_outstanding;
                for (int i = 0; i < n_resend; i++) begin
                    pending_results.push_back(frame_res(mdl_next_seq));
                    mdl_next_seq = mdl_next_seq + t_seq'(1);
                end
            end
            default: begin
            end
        endcase
        pending_results.push_back(status_res(mdl_outstanding < MAX_SEQUENCE, turned_away));
        if (turned_away) refusals_seen++;
        if (pending_results.size() - base > largest_burst)
            largest_burst = pending_results.size() - base;
    endfunction

    // Mostly well-formed traffic: in-order frames and acks inside the window
    function automatic t_cmd random_event();
        t_cmd ev;
        int   pick;
        ev.rx_seq  = t_seq'($urandom_range(0, 7));
        ev.rx_ack  = t_seq'($urandom_range(0, 7));
        ev.payload = $urandom();
        if ($urandom_range(0, 15) == 0)
            ev.payload = $urandom_range(0, 1) ? '1 : '0;
        pick = $urandom_range(0, 99);
        if (pick < 42) begin
            ev.op = OP_SEND;
        end else if (pick < 80) begin
            ev.op = OP_FRAME;
            if ($urandom_range(0, 3) != 0)
                ev.rx_seq = mdl_rx_expected;
            if (mdl_outstanding > 0 && $urandom_range(0, 3) != 0)
                ev.rx_ack = mdl_oldest + t_seq'($urandom_range(0, mdl_outstanding - 1));
        end else if (pick < 88) begin
            ev.op = OP_CHKERR;
        end else begin
            ev.op = OP_TIMEOUT;
        end
        return ev;
    endfunction

    // Offer one event, hold it until the transfer, then queue what it should produce
    task automatic offer_event(input t_cmd ev, input int n_typed, input t_result [1:0] typed);
        int base;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.command    <= ev.op;
        in_if.rx_seq     <= ev.rx_seq;
        in_if.rx_ack     <= ev.rx_ack;
        in_if.payload_in <= ev.payload;
        do @(posedge clk); while (!in_if.ready);
        events_accepted++;
        events_by_op[ev.op]++;
        base = pending_results.size();
        predict_link_event(ev);
        // Typed rows replace the predicted results with the hand-written ones
        if (n_typed > 0) begin
            while (pending_results.size() > base) void'(pending_results.pop_back());
            for (int i = 0; i < n_typed; i++) pending_results.push_back(typed[i]);
        end
    endtask

    // Hold valid low until every queued result has been taken
    task automatic drain_results();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Stimulus
    initial begin
        rst_n            <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.command    <= OP_CHKERR;
        in_if.rx_seq     <= '0;
        in_if.rx_ack     <= '0;
        in_if.payload_in <= '0;
        mdl_next_seq    = '0;
        mdl_oldest      = '0;
        mdl_rx_expected = '0;
        mdl_outstanding = 0;
        foreach (sent_payloads[i]) sent_payloads[i] = '0;
        quiet_phase = 1'b0;

        // Reset view: nothing outstanding, window open
        stim_table[0]  = mk_row(OP_CHKERR,  3'd0, 3'd0, 32'h0000_0000, 1,
                                status_res(1'b1, 1'b0), NO_RES);
        // Timeout with nothing outstanding resends nothing
        stim_table[1]  = mk_row(OP_TIMEOUT, 3'd7, 3'd7, 32'hFFFF_FFFF, 1,
                                status_res(1'b1, 1'b0), NO_RES);
        stim_table[2]  = mk_row(OP_FRAME,   3'd0, 3'd0, 32'h0000_0000, 2,
                                deliver_res(32'h0000_0000), status_res(1'b1, 1'b0));
        stim_table[3]  = mk_row(OP_SEND,    3'd0, 3'd0, 32'hFFFF_FFFF, 2,
                                '{KIND_SEND, 3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0},
                                status_res(1'b1, 1'b0));
        // Fill the window
        stim_table[4]  = mk_row(OP_SEND,    3'd5, 3'd2, 32'h0000_0000, 0, NO_RES, NO_RES);
        stim_table[5]  = mk_row(OP_SEND,    3'd0, 3'd0, 32'hA5A5_A5A5, 0, NO_RES, NO_RES);
        stim_table[6]  = mk_row(OP_SEND,    3'd7, 3'd7, 32'h5A5A_5A5A, 0, NO_RES, NO_RES);
        stim_table[7]  = mk_row(OP_SEND,    3'd1, 3'd6, 32'h0000_0001, 0, NO_RES, NO_RES);
        stim_table[8]  = mk_row(OP_SEND,    3'd2, 3'd5, 32'h8000_0000, 0, NO_RES, NO_RES);
        stim_table[9]  = mk_row(OP_SEND,    3'd4, 3'd3, 32'h7FFF_FFFF, 0, NO_RES, NO_RES);
        // Window full: packet dropped and flagged
        stim_table[10] = mk_row(OP_SEND,    3'd0, 3'd0, 32'h1234_5678, 1,
                                status_res(1'b0, 1'b1), NO_RES);
        // Resend all seven
        stim_table[11] = mk_row(OP_TIMEOUT, 3'd0, 3'd0, 32'h0000_0000, 0, NO_RES, NO_RES);
        // Out-of-order frame with an ack outside the window
        stim_table[12] = mk_row(OP_FRAME,   3'd7, 3'd7, 32'hDEAD_BEEF, 1,
                                status_res(1'b0, 1'b0), NO_RES);
        stim_table[13] = mk_row(OP_CHKERR,  3'd7, 3'd7, 32'hFFFF_FFFF, 1,
                                status_res(1'b0, 1'b0), NO_RES);
        // Delivery plus seven timer stops
        stim_table[14] = mk_row(OP_FRAME,   3'd1, 3'd6, 32'hCAFE_F00D, 0, NO_RES, NO_RES);
        stim_table[15] = mk_row(OP_FRAME,   3'd2, 3'd5, 32'hFFFF_FFFF, 2,
                                deliver_res(32'hFFFF_FFFF), status_res(1'b1, 1'b0));
        // Wrap the send sequence
        stim_table[16] = mk_row(OP_SEND,    3'd0, 3'd0, 32'h0F0F_0F0F, 0, NO_RES, NO_RES);
        stim_table[17] = mk_row(OP_SEND,    3'd0, 3'd0, 32'hF0F0_F0F0, 0, NO_RES, NO_RES);
        stim_table[18] = mk_row(OP_FRAME,   3'd0, 3'd7, 32'h0000_0000, 0, NO_RES, NO_RES);
        stim_table[19] = mk_row(OP_TIMEOUT, 3'd5, 3'd1, 32'h0000_0000, 0, NO_RES, NO_RES);
        stim_table[20] = mk_row(OP_FRAME,   3'd3, 3'd0, 32'h0000_0000, 0, NO_RES, NO_RES);
        stim_table[21] = mk_row(OP_SEND,    3'd7, 3'd7, 32'hFFFF_FFFF, 0, NO_RES, NO_RES);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
            offer_event(stim_table[r].ev, stim_table[r].n_typed, stim_table[r].typed);
        drain_results();

        for (int k = 0; k < RANDOM_EVENTS; k++) begin
            if (k == RANDOM_EVENTS / 2) drain_results();
            if (k == RANDOM_EVENTS - QUIET_TAIL) quiet_phase = 1'b1;
            offer_event(random_event(), 0, '0);
        end

        // Wait out the tail, then give the block time to show any stray result
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display(
            "covered %0d events: %0d send (%0d refused), %0d frame, %0d bad checksum, %0d timeout",
            events_accepted, events_by_op[OP_SEND], refusals_seen, events_by_op[OP_FRAME],
            events_by_op[OP_CHKERR], events_by_op[OP_TIMEOUT]);
        $display(
            "checked %0d results: %0d sent, %0d delivered, %0d stops, max burst %0d",
            results_seen, results_by_kind[KIND_SEND], results_by_kind[KIND_DELIVER],
            results_by_kind[KIND_STOP], largest_burst);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Result side: random stalls, one long hold-off, none at the end
    initial begin
        out_if.ready <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!long_hold_done && events_accepted >= N_ROWS + 40) begin
                long_hold_done = 1'b1;
                out_if.ready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++) @(posedge clk);
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
            out_if.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // Compare every result transfer against the oldest expectation
    always @(posedge clk) begin
        t_result got;
        t_result want;
        if (rst_n && out_if.valid && out_if.ready) begin
            got.kind           = t_kind'(out_if.kind);
            got.seq_out        = out_if.seq_out;
            got.ack_out        = out_if.ack_out;
            got.payload_out    = out_if.payload_out;
            got.network_enable = out_if.network_enable;
            got.refused        = out_if.refused;
            got.last           = out_if.last;
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("cycle %0d: unexpected result kind=%0d seq=%0d pay=%h last=%b",
                             cycle_count, got.kind, got.seq_out, got.payload_out, got.last);
            end else begin
                want = pending_results.pop_front();
                results_by_kind[want.kind]++;
                if (got.kind !== want.kind || got.seq_out !== want.seq_out ||
                    got.ack_out !== want.ack_out || got.payload_out !== want.payload_out ||
                    got.network_enable !== want.network_enable ||
                    got.refused !== want.refused || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display(
                            "cycle %0d want kind=%0d seq=%0d ack=%0d pay=%h ne=%b ref=%b last=%b",
                            cycle_count, want.kind, want.seq_out, want.ack_out,
                            want.payload_out, want.network_enable, want.refused, want.last);
                        $display(
                            "cycle %0d got  kind=%0d seq=%0d ack=%0d pay=%h ne=%b ref=%b last=%b",
                            cycle_count, got.kind, got.seq_out, got.ack_out,
                            got.payload_out, got.network_enable, got.refused, got.last);
                    end
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

endmodule
